/* rtl/sase_pkg.sv */
// Package for the escape sequence stripper: widths, byte codes, parser modes, result type.
package sase_pkg;

    // Width of the kept byte counter and of the reported length
    localparam int LENGTH_WIDTH = 16;
    localparam int OUT_LENGTH_W = 16;

    // Byte codes
    localparam logic [7:0] BYTE_NUL    = 8'h00;
    localparam logic [7:0] BYTE_BEL    = 8'h07;
    localparam logic [7:0] BYTE_ESC    = 8'h1B;
    localparam logic [7:0] BYTE_CSI8   = 8'h9B;
    localparam logic [7:0] BYTE_OSC8   = 8'h9D;
    localparam logic [7:0] BYTE_DCS8   = 8'h90;
    localparam logic [7:0] BYTE_ST8    = 8'h9C;
    localparam logic [7:0] BYTE_LBRACK = 8'h5B;
    localparam logic [7:0] BYTE_RBRACK = 8'h5D;
    localparam logic [7:0] BYTE_BSLASH = 8'h5C;
    localparam logic [7:0] BYTE_DCS    = 8'h50;
    localparam logic [7:0] BYTE_SOS    = 8'h58;
    localparam logic [7:0] BYTE_PM     = 8'h5E;
    localparam logic [7:0] BYTE_APC    = 8'h5F;
    localparam logic [7:0] INT_LO      = 8'h20;
    localparam logic [7:0] INT_HI      = 8'h2F;
    localparam logic [7:0] FIN_ESC_LO  = 8'h30;
    localparam logic [7:0] FIN_CSI_LO  = 8'h40;
    localparam logic [7:0] FIN_HI      = 8'h7E;

    // Parser modes
    localparam logic [3:0] M_PLAIN   = 4'd0;
    localparam logic [3:0] M_ESC     = 4'd1;
    localparam logic [3:0] M_ESC_INT = 4'd2;
    localparam logic [3:0] M_CSI     = 4'd3;
    localparam logic [3:0] M_OSC     = 4'd4;
    localparam logic [3:0] M_OSC_ESC = 4'd5;
    localparam logic [3:0] M_STR     = 4'd6;
    localparam logic [3:0] M_STR_ESC = 4'd7;
    localparam logic [3:0] M_STR8    = 4'd8;

    // One result beat
    typedef struct packed {
        logic [7:0]              out_byte;
        logic                    out_last;
        logic [OUT_LENGTH_W-1:0] out_length;
    } sase_result_t;

    // Clamp the kept count to the reported length width
    function automatic logic [OUT_LENGTH_W-1:0] sat_length(input logic [LENGTH_WIDTH-1:0] n);
        logic [31:0] wide;
        wide = 32'(n);
        if (wide > 32'h0000_FFFF) begin
            return {OUT_LENGTH_W{1'b1}};
        end
        return wide[OUT_LENGTH_W-1:0];
    endfunction

endpackage

/* rtl/sase_if.sv */
// Stream interfaces for the text byte input and the result output.
interface sase_in_if import sase_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface sase_out_if import sase_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [7:0]              out_byte;
    logic                    out_last;
    logic [OUT_LENGTH_W-1:0] out_length;

    modport source (output valid, output out_byte, output out_last, output out_length,
                    input ready);
    modport sink   (input valid, input out_byte, input out_last, input out_length,
                    output ready);
endinterface

/* rtl/sase_in_reg.sv */
// Input register stage: captures one text byte per beat.
module sase_in_reg import sase_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    sase_in_if.sink    text,
    input  logic       take,
    output logic       held_valid,
    output logic [7:0] held_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       load;

    // Ready whenever the stage is empty or is being emptied this cycle
    assign text.ready = !valid_reg || take;
    assign load       = text.valid && text.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= text.in_byte;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

endmodule

/* rtl/sase_parser.sv */
// Escape sequence parser: mode and kept count registers with the per-byte decision logic.
module sase_parser import sase_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   cur_byte,
    output logic         emit,
    output sase_result_t result
);

    logic [3:0]              mode_reg;
    logic [3:0]              mode_next;
    logic [LENGTH_WIDTH-1:0] count_reg;
    logic [LENGTH_WIDTH-1:0] count_next;
    logic                    as_plain;
    logic                    is_int;
    logic                    is_esc_fin;
    logic                    is_csi_fin;

    assign is_int     = (cur_byte >= INT_LO) && (cur_byte <= INT_HI);
    assign is_esc_fin = (cur_byte >= FIN_ESC_LO) && (cur_byte <= FIN_HI);
    assign is_csi_fin = (cur_byte >= FIN_CSI_LO) && (cur_byte <= FIN_HI);

    // Next mode and result for the byte in the input register
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        as_plain   = 1'b0;
        emit       = 1'b0;
        result     = '{out_byte: cur_byte, out_last: 1'b0, out_length: '0};

        if (cur_byte == BYTE_NUL)
        begin
            // End of string in any mode: terminator with the kept length
            emit       = 1'b1;
            result     = '{out_byte: BYTE_NUL, out_last: 1'b1,
                           out_length: sat_length(count_reg)};
            mode_next  = M_PLAIN;
            count_next = '0;
        end
        else
        begin
            unique case (mode_reg)
                M_ESC:
                begin
                    if (cur_byte == BYTE_LBRACK)
                    begin
                        mode_next = M_CSI;
                    end
                    else if (cur_byte == BYTE_RBRACK)
                    begin
                        mode_next = M_OSC;
                    end
                    else if (cur_byte == BYTE_DCS || cur_byte == BYTE_SOS ||
                             cur_byte == BYTE_PM || cur_byte == BYTE_APC)
                    begin
                        mode_next = M_STR;
                    end
                    else if (is_int)
                    begin
                        mode_next = M_ESC_INT;
                    end
                    else if (is_esc_fin)
                    begin
                        mode_next = M_PLAIN;
                    end
                    else
                    begin
                        as_plain = 1'b1;
                    end
                end
                M_ESC_INT:
                begin
                    if (is_int)
                    begin
                        mode_next = M_ESC_INT;
                    end
                    else if (is_esc_fin)
                    begin
                        mode_next = M_PLAIN;
                    end
                    else
                    begin
                        as_plain = 1'b1;
                    end
                end
                M_CSI:
                begin
                    if (is_csi_fin)
                    begin
                        mode_next = M_PLAIN;
                    end
                end
                M_OSC, M_OSC_ESC:
                begin
                    // A backslash only terminates straight after ESC
                    if (mode_reg == M_OSC_ESC && cur_byte == BYTE_BSLASH)
                    begin
                        mode_next = M_PLAIN;
                    end
                    else if (cur_byte == BYTE_BEL)
                    begin
                        mode_next = M_PLAIN;
                    end
                    else if (cur_byte == BYTE_ESC)
                    begin
                        mode_next = M_OSC_ESC;
                    end
                    else
                    begin
                        mode_next = M_OSC;
                    end
                end
                M_STR, M_STR_ESC:
                begin
                    if (mode_reg == M_STR_ESC && cur_byte == BYTE_BSLASH)
                    begin
                        mode_next = M_PLAIN;
                    end
                    else if (cur_byte == BYTE_ESC)
                    begin
                        mode_next = M_STR_ESC;
                    end
                    else
                    begin
                        mode_next = M_STR;
                    end
                end
                M_STR8:
                begin
                    if (cur_byte == BYTE_ST8)
                    begin
                        mode_next = M_PLAIN;
                    end
                end
                default:
                begin
                    // Plain text, and any mode code that names no mode
                    as_plain = 1'b1;
                end
            endcase

            // Plain text handling: introducers or a kept byte
            if (as_plain)
            begin
                if (cur_byte == BYTE_ESC)
                begin
                    mode_next = M_ESC;
                end
                else if (cur_byte == BYTE_CSI8)
                begin
                    mode_next = M_CSI;
                end
                else if (cur_byte == BYTE_OSC8 || cur_byte == BYTE_DCS8)
                begin
                    mode_next = M_STR8;
                end
                else
                begin
                    mode_next = M_PLAIN;
                    emit      = 1'b1;
                    if (count_reg != {LENGTH_WIDTH{1'b1}})
                    begin
                        count_next = count_reg + LENGTH_WIDTH'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_PLAIN;
            count_reg <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/sase_out_reg.sv */
// Result register stage: holds one result beat until the sink takes it.
module sase_out_reg import sase_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  sase_result_t load_data,
    output logic         free,
    sase_out_if.source   result
);

    logic         valid_reg;
    logic         valid_next;
    sase_result_t data_reg;

    // Free when empty or when the current beat leaves this cycle
    assign free = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign result.valid      = valid_reg;
    assign result.out_byte   = data_reg.out_byte;
    assign result.out_last   = data_reg.out_last;
    assign result.out_length = data_reg.out_length;

endmodule

/* rtl/strip_ansi_escape_sequences_core.sv */
// Top level of the ANSI escape sequence stripper.
// Takes one text byte per beat and passes on only plain bytes, dropping 7-bit and 8-bit CSI,
// OSC, DCS/SOS/PM/APC and ESC-with-intermediates sequences. A zero byte ends the string and
// yields a terminator beat (out_last high, out_byte zero) carrying the kept byte count,
// saturated at 65535; the parser then returns to plain text with the count cleared. Dropped
// bytes yield no beat. A byte goes through an input register, the parser logic and a result
// register, so the block sustains one byte per clock while the sink takes beats; while
// a finished result waits to be taken the input register still takes one more byte, and the
// input stalls once both registers are full and the sink holds ready low.
module strip_ansi_escape_sequences_core import sase_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    sase_in_if.sink    text,
    sase_out_if.source result
);

    logic         held_valid;
    logic [7:0]   held_byte;
    logic         out_free;
    logic         step;
    logic         emit;
    sase_result_t parsed;

    // The held byte is processed whenever the result register can accept a beat
    assign step = held_valid && out_free;

    sase_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .text       (text),
        .take       (out_free),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sase_parser u_parser (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .cur_byte (held_byte),
        .emit     (emit),
        .result   (parsed)
    );

    sase_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && emit),
        .load_data (parsed),
        .free      (out_free),
        .result    (result)
    );

endmodule

/* test/tb_strip_ansi_escape_sequences_core.sv */
// Testbench for the escape sequence stripper: random and directed byte streams checked beat by beat.
module tb_strip_ansi_escape_sequences_core;
    import sase_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RANDOM_ITEMS = 1030;
    localparam int          HELD_STRING  = 40;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          LIMIT_CYCLES = 3_000_000;
    localparam int          REPORT_CAP   = 100;
    localparam logic [31:0] LEN_MAX      = (32'd1 << OUT_LENGTH_W) - 32'd1;

    typedef struct {
        logic [7:0] value;
        bit         hold;
    } text_item_t;

    logic clk;
    logic rst_n;

    sase_in_if  text_if ();
    sase_out_if result_if ();

    strip_ansi_escape_sequences_core u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_if),
        .result (result_if)
    );

    // Pending text bytes and the beats the stripper should produce
    text_item_t   text_q[$];
    sase_result_t kept_beats_q[$];

    // Parser state mirrored on the testbench side
    logic [3:0]              pmode = M_PLAIN;
    logic [LENGTH_WIDTH-1:0] kept_bytes = '0;

    int errors = 0;
    int cycles = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_style = 0;
    int stall_span = 0;

    always #2 clk = ~clk;

    function automatic void queue_byte(input logic [7:0] b, input bit hold = 1'b0);
        text_item_t it;
        it.value = b;
        it.hold  = hold;
        text_q.push_back(it);
    endfunction

    // Random byte that neither opens a sequence nor ends the string
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == BYTE_ESC || c == BYTE_CSI8 || c == BYTE_OSC8 || c == BYTE_DCS8);
        return c;
    endfunction

    // Advance the parser by one accepted byte and queue the beat it yields, if any
    function automatic void track_byte(input logic [7:0] b);
        sase_result_t beat;
        logic         emit;
        logic         as_plain;
        emit     = 1'b0;
        as_plain = 1'b0;
        beat     = '0;
        if (b == BYTE_NUL)
        begin
            // end of string, possibly inside a sequence
            beat.out_last   = 1'b1;
            beat.out_length = (32'(kept_bytes) > LEN_MAX) ? {OUT_LENGTH_W{1'b1}}
                                                          : OUT_LENGTH_W'(kept_bytes);
            pmode      = M_PLAIN;
            kept_bytes = '0;
            emit       = 1'b1;
        end
        else
        begin
            case (pmode)
                M_ESC:
                begin
                    if (b == BYTE_LBRACK)
                        pmode = M_CSI;
                    else if (b == BYTE_RBRACK)
                        pmode = M_OSC;
                    else if (b == BYTE_DCS || b == BYTE_SOS || b == BYTE_PM || b == BYTE_APC)
                        pmode = M_STR;
                    else if (b >= INT_LO && b <= INT_HI)
                        pmode = M_ESC_INT;
                    else if (b >= FIN_ESC_LO && b <= FIN_HI)
                        pmode = M_PLAIN;
                    else
                        as_plain = 1'b1;   // unknown escape: only the ESC goes
                end
                M_ESC_INT:
                begin
                    if (b >= FIN_ESC_LO && b <= FIN_HI)
                        pmode = M_PLAIN;
                    else if (b < INT_LO || b > FIN_HI)
                        as_plain = 1'b1;   // broken intermediates
                end
                M_CSI:
                begin
                    if (b >= FIN_CSI_LO && b <= FIN_HI)
                        pmode = M_PLAIN;
                end
                M_OSC, M_OSC_ESC:
                begin
                    if (pmode == M_OSC_ESC && b == BYTE_BSLASH)
                        pmode = M_PLAIN;
                    else if (b == BYTE_BEL)
                        pmode = M_PLAIN;
                    else if (b == BYTE_ESC)
                        pmode = M_OSC_ESC;
                    else
                        pmode = M_OSC;
                end
                M_STR, M_STR_ESC:
                begin
                    if (pmode == M_STR_ESC && b == BYTE_BSLASH)
                        pmode = M_PLAIN;
                    else if (b == BYTE_ESC)
                        pmode = M_STR_ESC;
                    else
                        pmode = M_STR;
                end
                M_STR8:
                begin
                    if (b == BYTE_ST8)
                        pmode = M_PLAIN;
                end
                default:
                    as_plain = 1'b1;
            endcase
            if (as_plain)
            begin
                if (b == BYTE_ESC)
                    pmode = M_ESC;
                else if (b == BYTE_CSI8)
                    pmode = M_CSI;
                else if (b == BYTE_OSC8 || b == BYTE_DCS8)
                    pmode = M_STR8;
                else
                begin
                    pmode = M_PLAIN;
                    if (kept_bytes != {LENGTH_WIDTH{1'b1}})
                        kept_bytes = kept_bytes + LENGTH_WIDTH'(1);
                    beat.out_byte = b;
                    emit          = 1'b1;
                end
            end
        end
        if (emit)
            kept_beats_q.push_back(beat);
    endfunction

    // Sender: bursts of random length with random gaps
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (text_if.valid && text_if.ready)
                track_byte(text_if.in_byte);
            if (!text_if.valid || text_if.ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left = gap_left - 1;
                    text_if.valid <= 1'b0;
                end
                else if (text_q.size() != 0 &&
                         !(text_q[0].hold && kept_beats_q.size() != 0))
                begin
                    text_if.valid   <= 1'b1;
                    text_if.in_byte <= text_q[0].value;
                    void'(text_q.pop_front());
                    if (burst_left <= 1)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left = burst_left - 1;
                end
                else
                    text_if.valid <= 1'b0;
            end
        end
    end

    // Receiver: check each result beat and stall on a changing pattern
    always @(posedge clk)
    begin
        sase_result_t want;
        if (rst_n)
        begin
            if (result_if.valid && result_if.ready)
            begin
                if (kept_beats_q.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= REPORT_CAP)
                        $error("unexpected result beat: out_byte %0h out_last %0b out_length %0d",
                               result_if.out_byte, result_if.out_last, result_if.out_length);
                end
                else
                begin
                    want = kept_beats_q.pop_front();
                    if (result_if.out_byte !== want.out_byte)
                    begin
                        errors = errors + 1;
                        if (errors <= REPORT_CAP)
                            $error("out_byte: expected %0h, actual %0h",
                                   want.out_byte, result_if.out_byte);
                    end
                    if (result_if.out_last !== want.out_last)
                    begin
                        errors = errors + 1;
                        if (errors <= REPORT_CAP)
                            $error("out_last: expected %0b, actual %0b",
                                   want.out_last, result_if.out_last);
                    end
                    if (result_if.out_length !== want.out_length)
                    begin
                        errors = errors + 1;
                        if (errors <= REPORT_CAP)
                            $error("out_length: expected %0d, actual %0d",
                                   want.out_length, result_if.out_length);
                    end
                end
            end
            if (stall_span == 0)
            begin
                stall_style = $urandom_range(0, 3);
                stall_span  = $urandom_range(20, 200);
            end
            else
                stall_span = stall_span - 1;
            case (stall_style)
                0:       result_if.ready <= 1'b1;
                1:       result_if.ready <= ($urandom_range(0, 3) != 0);
                2:       result_if.ready <= ((cycles % 5) < 3);
                default: result_if.ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles = cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        logic [7:0] directed [] = '{
            8'h41, 8'hFF,                                  // plain extremes
            BYTE_ESC, 8'h80,                               // unknown escape
            BYTE_ESC, 8'h28, 8'h01,                        // broken intermediates
            BYTE_ESC, BYTE_RBRACK, 8'h61, BYTE_ESC, 8'h71, // stray ESC inside OSC
            BYTE_ESC, BYTE_BSLASH,
            BYTE_CSI8, 8'h31, BYTE_NUL,                    // end inside a sequence
            BYTE_NUL,                                      // empty string
            BYTE_ESC, BYTE_LBRACK, 8'h6D,
            BYTE_DCS8, BYTE_ST8
        };
        int         start;
        int         kind;
        logic [7:0] c;

        clk             = 1'b0;
        rst_n           = 1'b0;
        text_if.valid   = 1'b0;
        text_if.in_byte = 8'h00;
        result_if.ready = 1'b0;

        // Directed part
        foreach (directed[i])
            queue_byte(directed[i]);

        // Random part: mostly well-formed sequences with random content
        start = text_q.size();
        while (text_q.size() - start < RANDOM_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 25)
            begin
                repeat ($urandom_range(1, 8))
                    queue_byte(plain_char());
            end
            else if (kind < 37)
            begin
                // 7-bit or 8-bit CSI
                if ($urandom_range(0, 1))
                begin
                    queue_byte(BYTE_ESC);
                    queue_byte(BYTE_LBRACK);
                end
                else
                    queue_byte(BYTE_CSI8);
                repeat ($urandom_range(0, 4))
                    queue_byte(8'($urandom_range(8'h20, 8'h3F)));
                queue_byte(8'($urandom_range(FIN_CSI_LO, FIN_HI)));
            end
            else if (kind < 47)
            begin
                // OSC ended by BEL or ESC backslash
                queue_byte(BYTE_ESC);
                queue_byte(BYTE_RBRACK);
                repeat ($urandom_range(0, 6))
                begin
                    c = ($urandom_range(0, 7) == 0) ? BYTE_ESC : 8'($urandom_range(1, 255));
                    queue_byte(c);
                end
                if ($urandom_range(0, 1))
                    queue_byte(BYTE_BEL);
                else
                begin
                    queue_byte(BYTE_ESC);
                    queue_byte(BYTE_BSLASH);
                end
            end
            else if (kind < 56)
            begin
                // DCS, SOS, PM or APC string
                queue_byte(BYTE_ESC);
                case ($urandom_range(0, 3))
                    0:       queue_byte(BYTE_DCS);
                    1:       queue_byte(BYTE_SOS);
                    2:       queue_byte(BYTE_PM);
                    default: queue_byte(BYTE_APC);
                endcase
                repeat ($urandom_range(0, 6))
                begin
                    c = ($urandom_range(0, 7) == 0) ? BYTE_ESC : 8'($urandom_range(1, 255));
                    queue_byte(c);
                end
                queue_byte(BYTE_ESC);
                queue_byte(BYTE_BSLASH);
            end
            else if (kind < 64)
            begin
                // 8-bit OSC or DCS up to the string terminator
                queue_byte($urandom_range(0, 1) ? BYTE_OSC8 : BYTE_DCS8);
                repeat ($urandom_range(0, 6))
                    queue_byte(8'($urandom_range(1, 255)));
                queue_byte(BYTE_ST8);
            end
            else if (kind < 72)
            begin
                // ESC, intermediates, final
                queue_byte(BYTE_ESC);
                repeat ($urandom_range(0, 3))
                    queue_byte(8'($urandom_range(INT_LO, INT_HI)));
                queue_byte(8'($urandom_range(FIN_ESC_LO, FIN_HI)));
            end
            else if (kind < 80)
            begin
                // unknown escape or broken intermediates
                queue_byte(BYTE_ESC);
                if ($urandom_range(0, 1))
                    queue_byte(8'($urandom_range(INT_LO, INT_HI)));
                c = $urandom_range(0, 1) ? 8'($urandom_range(1, 8'h1F))
                                         : 8'($urandom_range(8'h7F, 8'hFF));
                queue_byte(c);
            end
            else if (kind < 88)
                queue_byte(BYTE_NUL);
            else
            begin
                repeat ($urandom_range(1, 4))
                    queue_byte(8'($urandom_range(0, 255)));
            end
        end
        // drain before the random part starts
        text_q[start].hold = 1'b1;

        // A plain string sent after a full drain
        queue_byte(BYTE_NUL, 1'b1);
        repeat (HELD_STRING)
            queue_byte(plain_char());
        queue_byte(BYTE_NUL);
        queue_byte(8'h41);
        queue_byte(BYTE_NUL);

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Wait for everything to be sent and every beat to arrive
        while (text_q.size() != 0 || text_if.valid || kept_beats_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
